>>> sv/cas_pkg.sv
// cas_pkg: shared types and codes for the class accuracy statistics block
// no dependencies
`default_nettype none

package cas_pkg;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_RPT_RD,
        S_RPT_CHK,
        S_RPT_DIV,
        S_RPT_SQ,
        S_RPT_ACC,
        S_MUL,
        S_SUB,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_MEAN_WAIT,
        S_DEV_WAIT,
        S_OUT
    } state_t;

    // divider operand selection
    typedef enum logic [1:0] {
        DIV_RATE,
        DIV_MEAN,
        DIV_DEV
    } div_sel_t;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY_ROW = 2'd1;
    localparam logic [1:0] ST_BAD_LABEL = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic     latch_item;
        logic     rd_en;
        logic     rd_class;
        logic     wr_en;
        logic     acc_clr;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_rate;
        logic     acc_sq;
        logic     mul_en;
        logic     sub_en;
        logic     sqrt_start;
        logic     mean_load;
        logic     dev_load;
        logic     set_empty;
        logic     load_out;
        logic     clear_stores;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic item_last;
        logic row_zero;
        logic div_done;
        logic sqrt_done;
        logic last_class;
    } sts_t;

endpackage

`default_nettype wire

>>> sv/cas_ram.sv
// cas_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module cas_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/cas_div.sv
// cas_div: iterative restoring divider, one quotient bit per cycle
// no dependencies
`default_nettype none

module cas_div #(
    parameter int NUMW = 36,
    parameter int DENW = 20
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [NUMW-1:0] num,
    input  wire logic [DENW-1:0] den,
    output logic                 done,
    output logic      [NUMW-1:0] quot
);

    localparam int CNTW = $clog2(NUMW + 1);

    logic [DENW-1:0] rem_reg;
    logic [DENW-1:0] den_reg;
    logic [NUMW-1:0] q_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DENW:0]   rem_sh;
    logic [DENW:0]   rem_sub;
    logic            fits;

    // one trial subtraction
    assign rem_sh  = {rem_reg, q_reg[NUMW-1]};
    assign fits    = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(NUMW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= den;
            q_reg   <= num;
        end else if (busy_reg) begin
            rem_reg <= fits ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
            q_reg   <= {q_reg[NUMW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

>>> sv/cas_sqrt.sv
// cas_sqrt: iterative integer square root, one root bit per cycle
// no dependencies
`default_nettype none

module cas_sqrt #(
    parameter int W = 53
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [W-1:0]         din,
    output logic                      done,
    output logic      [(W+1)/2-1:0]   root
);

    localparam int RW   = (W + 1) / 2;
    localparam int CNTW = $clog2(RW + 1);

    logic [2*RW-1:0] x_reg;
    logic [RW:0]     rem_reg;
    logic [RW-1:0]   root_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [RW+2:0]   rem_sh;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   rem_sub;
    logic            fits;

    // one trial step on two radicand bits
    assign rem_sh  = {rem_reg, x_reg[2*RW-1:2*RW-2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign fits    = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // root, remainder and radicand shift
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= (2*RW)'(din);
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[2*RW-3:0], 2'b00};
            rem_reg  <= fits ? rem_sub[RW:0] : rem_sh[RW:0];
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

>>> sv/cas_datapath.sv
// cas_datapath: count store, rate accumulation and final statistics
// depends on cas_pkg, cas_ram, cas_div, cas_sqrt
`default_nettype none

module cas_datapath #(
    parameter int MAX_CLASSES = 32,
    parameter int COUNT_WIDTH = 20
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [5:0]   cfg_wr_data,
    input  wire logic [4:0]   s_true_label,
    input  wire logic [4:0]   s_predicted_label,
    input  wire logic         s_last,
    input  wire cas_pkg::cmd_t cmd,
    output cas_pkg::sts_t     sts,
    output logic      [16:0]  m_mean_rate,
    output logic      [15:0]  m_rate_deviation,
    output logic      [1:0]   m_status
);

    import cas_pkg::*;

    localparam int AW   = $clog2(MAX_CLASSES);
    localparam int NW   = $clog2(MAX_CLASSES + 1);
    localparam int CW   = (NW > 5) ? NW : 5;
    localparam int EW   = (NW > 6) ? NW : 6;
    localparam int SUMW = NW + 16;
    localparam int SQW  = 34;
    localparam int SSQW = NW + SQW;
    localparam int VW   = NW + SSQW;
    localparam int RW   = (VW + 1) / 2;
    localparam int NUMW = (COUNT_WIDTH + 16 > RW) ? COUNT_WIDTH + 16 : RW;
    localparam int DENW = (COUNT_WIDTH > NW) ? COUNT_WIDTH : NW;
    localparam int RAMW = 2 * COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [5:0]             ncfg_reg;
    logic [NW-1:0]          n_eff;
    logic [AW-1:0]          item_addr_reg;
    logic                   item_diag_reg;
    logic                   item_bad_reg;
    logic                   item_last_reg;
    logic                   item_bad;
    logic [MAX_CLASSES-1:0] valid_reg;
    logic                   rd_valid_reg;
    logic                   bad_seen_reg;
    logic [NW-1:0]          cls_reg;
    logic [AW-1:0]          rd_addr;
    logic [RAMW-1:0]        ram_q;
    logic [COUNT_WIDTH-1:0] cur_diag;
    logic [COUNT_WIDTH-1:0] cur_row;
    logic [COUNT_WIDTH-1:0] diag_next;
    logic [COUNT_WIDTH-1:0] row_next;
    logic                   ram_we;
    logic [SUMW-1:0]        sum_reg;
    logic [SQW-1:0]         sq_reg;
    logic [SSQW-1:0]        sumsq_reg;
    logic [VW-1:0]          a_reg;
    logic [VW-1:0]          b_reg;
    logic [VW-1:0]          v_reg;
    logic                   empty_reg;
    logic [16:0]            mean_reg;
    logic [15:0]            dev_reg;
    logic [16:0]            rate;
    logic                   div_start;
    logic [NUMW-1:0]        div_num;
    logic [DENW-1:0]        div_den;
    logic                   div_done;
    logic [NUMW-1:0]        div_quot;
    logic                   sqrt_done;
    logic [RW-1:0]          sqrt_root;
    logic [16:0]            out_mean_reg;
    logic [15:0]            out_dev_reg;
    logic [1:0]             out_status_reg;

    // effective class count, clamped to the legal range
    always_comb begin
        if (ncfg_reg < 6'd2) begin
            n_eff = NW'(2);
        end else if (EW'(ncfg_reg) > EW'(MAX_CLASSES)) begin
            n_eff = NW'(MAX_CLASSES);
        end else begin
            n_eff = NW'(ncfg_reg);
        end
    end

    // label range check
    assign item_bad = (CW'(s_true_label) >= CW'(n_eff)) ||
                      (CW'(s_predicted_label) >= CW'(n_eff));

    // count store: {diagonal, row total} per class
    assign rd_addr = cmd.rd_class ? AW'(cls_reg) : AW'(s_true_label);
    assign ram_we  = cmd.wr_en && !item_bad_reg;

    cas_ram #(
        .WIDTH (RAMW),
        .DEPTH (MAX_CLASSES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (item_addr_reg),
        .wr_data ({diag_next, row_next}),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // an entry not written since the last clear reads as zero
    assign cur_diag = rd_valid_reg ? ram_q[RAMW-1:COUNT_WIDTH] : '0;
    assign cur_row  = rd_valid_reg ? ram_q[COUNT_WIDTH-1:0] : '0;

    // saturating increments
    assign row_next  = (cur_row < CNT_MAX) ? cur_row + COUNT_WIDTH'(1) : cur_row;
    assign diag_next = (item_diag_reg && cur_diag < CNT_MAX) ?
                       cur_diag + COUNT_WIDTH'(1) : cur_diag;

    // control state: config, valid bits, bad label flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncfg_reg     <= 6'd32;
            valid_reg    <= '0;
            bad_seen_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ncfg_reg <= cfg_wr_data;
            end
            if (cmd.clear_stores) begin
                valid_reg    <= '0;
                bad_seen_reg <= 1'b0;
            end else if (cmd.wr_en) begin
                if (item_bad_reg) begin
                    bad_seen_reg <= 1'b1;
                end else begin
                    valid_reg[item_addr_reg] <= 1'b1;
                end
            end
        end
    end

    // item capture and read valid
    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            item_addr_reg <= AW'(s_true_label);
            item_diag_reg <= s_true_label == s_predicted_label;
            item_bad_reg  <= item_bad;
            item_last_reg <= s_last;
        end
        if (cmd.rd_en) begin
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // shared divider operands
    assign div_start = cmd.div_start;
    always_comb begin
        unique case (cmd.div_sel)
            DIV_RATE: begin
                div_num = NUMW'({cur_diag, 16'h0000});
                div_den = DENW'(cur_row);
            end
            DIV_MEAN: begin
                div_num = NUMW'(sum_reg);
                div_den = DENW'(n_eff);
            end
            DIV_DEV: begin
                div_num = NUMW'(sqrt_root);
                div_den = DENW'(n_eff);
            end
            default: begin
                div_num = '0;
                div_den = DENW'(n_eff);
            end
        endcase
    end

    cas_div #(
        .NUMW (NUMW),
        .DENW (DENW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    cas_sqrt #(
        .W (VW)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.sqrt_start),
        .din     (v_reg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign rate = div_quot[16:0];

    // class walk and accumulation
    always_ff @(posedge aclk) begin
        if (cmd.acc_clr) begin
            cls_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            empty_reg <= 1'b0;
        end else begin
            if (cmd.take_rate) begin
                sq_reg  <= {17'd0, rate} * {17'd0, rate};
                sum_reg <= sum_reg + SUMW'(rate);
            end
            if (cmd.acc_sq) begin
                sumsq_reg <= sumsq_reg + SSQW'(sq_reg);
                cls_reg   <= cls_reg + NW'(1);
            end
            if (cmd.set_empty) begin
                empty_reg <= 1'b1;
            end
        end
        // variance numerator n*sum(r^2) - sum^2, clamped at zero
        if (cmd.mul_en) begin
            a_reg <= VW'(n_eff) * VW'(sumsq_reg);
            b_reg <= VW'(sum_reg) * VW'(sum_reg);
        end
        if (cmd.sub_en) begin
            v_reg <= (a_reg > b_reg) ? a_reg - b_reg : '0;
        end
        if (cmd.mean_load) begin
            mean_reg <= div_quot[16:0];
        end
        if (cmd.dev_load) begin
            dev_reg <= div_quot[15:0];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_mean_reg <= empty_reg ? 17'd0 : mean_reg;
            out_dev_reg  <= empty_reg ? 16'd0 : dev_reg;
            if (bad_seen_reg) begin
                out_status_reg <= ST_BAD_LABEL;
            end else if (empty_reg) begin
                out_status_reg <= ST_EMPTY_ROW;
            end else begin
                out_status_reg <= ST_OK;
            end
        end
    end

    assign m_mean_rate      = out_mean_reg;
    assign m_rate_deviation = out_dev_reg;
    assign m_status         = out_status_reg;

    // status to controller
    assign sts.item_last  = item_last_reg;
    assign sts.row_zero   = cur_row == '0;
    assign sts.div_done   = div_done;
    assign sts.sqrt_done  = sqrt_done;
    assign sts.last_class = cls_reg == NW'(n_eff - NW'(1));

endmodule

`default_nettype wire

>>> sv/cas_ctrl.sv
// cas_ctrl: sequencer for pair update, class walk and report
// depends on cas_pkg
`default_nettype none

module cas_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  wire logic          m_ready,
    input  wire cas_pkg::sts_t sts,
    output cas_pkg::cmd_t      cmd
);

    import cas_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (s_valid) state_next = S_UPD;
            S_UPD:       state_next = sts.item_last ? S_RPT_RD : S_IDLE;
            S_RPT_RD:    state_next = S_RPT_CHK;
            S_RPT_CHK:   state_next = sts.row_zero ? S_OUT : S_RPT_DIV;
            S_RPT_DIV:   if (sts.div_done) state_next = S_RPT_SQ;
            S_RPT_SQ:    state_next = S_RPT_ACC;
            S_RPT_ACC:   state_next = sts.last_class ? S_MUL : S_RPT_RD;
            S_MUL:       state_next = S_SUB;
            S_SUB:       state_next = S_SQRT_GO;
            S_SQRT_GO:   state_next = S_SQRT_WAIT;
            S_SQRT_WAIT: if (sts.sqrt_done) state_next = S_MEAN_WAIT;
            S_MEAN_WAIT: if (sts.div_done) state_next = S_DEV_WAIT;
            S_DEV_WAIT:  if (sts.div_done) state_next = S_OUT;
            S_OUT:       if (slot_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs and commands
    always_comb begin
        cmd          = '0;
        cmd.div_sel  = DIV_RATE;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_IDLE: begin
                s_ready        = 1'b1;
                cmd.latch_item = s_valid;
                cmd.rd_en      = s_valid;
            end
            S_UPD: begin
                cmd.wr_en   = 1'b1;
                cmd.acc_clr = sts.item_last;
            end
            S_RPT_RD: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_class = 1'b1;
            end
            S_RPT_CHK: begin
                cmd.set_empty = sts.row_zero;
                cmd.div_start = !sts.row_zero;
            end
            S_RPT_SQ:  cmd.take_rate = 1'b1;
            S_RPT_ACC: cmd.acc_sq = 1'b1;
            S_MUL:     cmd.mul_en = 1'b1;
            S_SUB:     cmd.sub_en = 1'b1;
            S_SQRT_GO: cmd.sqrt_start = 1'b1;
            S_SQRT_WAIT: begin
                cmd.div_sel   = DIV_MEAN;
                cmd.div_start = sts.sqrt_done;
            end
            S_MEAN_WAIT: begin
                cmd.mean_load = sts.div_done;
                cmd.div_sel   = DIV_DEV;
                cmd.div_start = sts.div_done;
            end
            S_DEV_WAIT: cmd.dev_load = sts.div_done;
            S_OUT: begin
                cmd.load_out     = slot_free;
                cmd.clear_stores = slot_free;
                if (slot_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    // the update step always follows an accepted request
    a_upd_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> $past(s_valid && s_ready))
        else $error("update step without an accepted request");

    // a result is never loaded over one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // squaring step only right after a divide finished
    a_sq_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RPT_SQ) |-> $past(sts.div_done))
        else $error("rate used before divide done");

    // no request taken while the report is in progress
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready)
        else $error("ready while busy");

endmodule

`default_nettype wire

>>> sv/class_accuracy_statistics_top.sv
// A non-last pair reads its count, then writes it back. A last pair adds
// the report: per class a count read, a row check, a divide, a square and
// an accumulate; then the variance product and subtraction, the root and
// the two divides by n, which use the divider that the per-class rates share.
// Requests are taken only while idle: none before the previous pair is
// written back, none during a report. The result register lets requests
// continue while a result waits. Reset (synchronous, low) clears all counts
// at once through per-class valid bits.
// depends on cas_pkg, cas_ctrl, cas_datapath
`default_nettype none

module class_accuracy_statistics_top #(
    parameter int MAX_CLASSES = 32,
    parameter int COUNT_WIDTH = 20
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [5:0]  cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [4:0]  s_true_label,
    input  wire logic [4:0]  s_predicted_label,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [16:0] m_mean_rate,
    output logic      [15:0] m_rate_deviation,
    output logic      [1:0]  m_status
);

    import cas_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer
    cas_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // datapath
    cas_datapath #(
        .MAX_CLASSES (MAX_CLASSES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_true_label      (s_true_label),
        .s_predicted_label (s_predicted_label),
        .s_last            (s_last),
        .cmd               (cmd),
        .sts               (sts),
        .m_mean_rate       (m_mean_rate),
        .m_rate_deviation  (m_rate_deviation),
        .m_status          (m_status)
    );

endmodule

`default_nettype wire
